// ===== rtl/sffdo_pkg.sv =====
// ----------------------------------------------------------------------------
// sffdo_pkg
// Shared types and constants of the stereo frame FIFO (drop oldest on full).
// ----------------------------------------------------------------------------
package sffdo_pkg;

    localparam int FIFO_FRAMES_DEF    = 1024;
    localparam int MAX_READ_BURST_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 2 * SAMPLE_W;
    localparam int CNT_W    = 11;
    localparam int DROP_W   = 32;

    typedef enum logic [1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_DISCARD = 2'd2,
        FUNC_CLEAR   = 2'd3
    } t_func;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        t_func                       func;
        logic signed [SAMPLE_W-1:0]  left_in;
        logic signed [SAMPLE_W-1:0]  right_in;
        logic        [CNT_W-1:0]     count;
    } t_req;

    typedef struct packed {
        logic                        frame_valid;
        logic signed [SAMPLE_W-1:0]  left_out;
        logic signed [SAMPLE_W-1:0]  right_out;
        logic                        last;
        logic        [CNT_W-1:0]     done_count;
        logic        [CNT_W-1:0]     occupancy;
        logic        [DROP_W-1:0]    dropped_total;
    } t_rsp;

endpackage

// ===== rtl/sffdo_ram.sv =====
// ----------------------------------------------------------------------------
// sffdo_ram
// Simple dual-port frame store: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module sffdo_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/stereo_frame_fifo_drop_oldest_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_frame_fifo_drop_oldest_unit
// Ring FIFO of stereo 16-bit frames that drops its oldest frame when full.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_stall with a t_req payload (push,
//   read, discard, clear). Results leave on o_out_valid / i_out_stall with a
//   t_rsp payload through an output register.
//   Push, discard, clear and a read that yields no frame give one result,
//   visible on the output in the cycle after the request.
//   A read of n frames (n = min(count, occupancy, MAX_READ_BURST)) issues one
//   frame-store read per cycle while the receiver takes results; the single
//   read port of the store sets the pace at one frame per cycle, and the next
//   request is taken once the last frame has left the store.
//   A push into a full FIFO drops the oldest frame and bumps the 32-bit
//   wrapping drop counter.
//   Reset clears the pointers, the occupancy and the drop counter; the frame
//   store keeps whatever it holds and is only read where it was written.
//   While the receiver stalls a valid result, the output register holds it,
//   frame reads pause once one frame waits and no new request is taken.
// ----------------------------------------------------------------------------
module stereo_frame_fifo_drop_oldest_unit #(
    parameter int FIFO_FRAMES    = sffdo_pkg::FIFO_FRAMES_DEF,
    parameter int MAX_READ_BURST = sffdo_pkg::MAX_READ_BURST_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sffdo_pkg::t_req i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sffdo_pkg::t_rsp o_out_data
);

    import sffdo_pkg::*;

    localparam int PW = $clog2(FIFO_FRAMES);
    localparam int HW = $clog2(FIFO_FRAMES + 1);
    localparam int MW = (HW > CNT_W) ? HW : CNT_W;
    localparam int SW = HW + 1;
    localparam int RW = $clog2(MAX_READ_BURST + 1);

    t_state r_state, n_state;

    logic [PW-1:0]     r_rp, n_rp;
    logic [PW-1:0]     r_wp, n_wp;
    logic [HW-1:0]     r_held, n_held;
    logic [DROP_W-1:0] r_drop, n_drop;
    logic [RW-1:0]     r_remain, n_remain;
    logic [RW-1:0]     r_done, n_done;

    logic              r_pend;
    logic              r_pend_last;
    logic [RW-1:0]     r_pend_done;
    logic [HW-1:0]     r_pend_occ;

    logic              r_out_valid;
    t_rsp              r_out;

    logic              in_acc;
    logic              in_ready;
    logic              out_free;
    logic              pend_move;
    logic              issue;
    logic              imm_load;
    logic [CNT_W-1:0]  imm_done;
    logic              go_read;
    logic              ram_we;
    logic [FRAME_W-1:0] ram_rdata;

    logic [MW-1:0]     cnt_m;
    logic [MW-1:0]     held_m;
    logic [MW-1:0]     min_m;
    logic [MW-1:0]     rd_m;
    logic [RW-1:0]     rd_n;
    logic [HW-1:0]     disc_n;
    logic [SW-1:0]     disc_sum;
    logic [PW-1:0]     disc_rp;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(FIFO_FRAMES - 1)) ? '0 : p + 1'b1;
    endfunction

    sffdo_ram #(
        .DEPTH (FIFO_FRAMES),
        .WIDTH (FRAME_W),
        .AW    (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata ({i_in_data.right_in, i_in_data.left_in}),
        .i_re    (issue),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    assign out_free  = !r_out_valid || !i_out_stall;
    assign pend_move = r_pend && out_free;
    assign in_acc    = i_in_valid && in_ready;

    // request sizes
    always_comb begin
        cnt_m    = MW'(i_in_data.count);
        held_m   = MW'(r_held);
        min_m    = (cnt_m < held_m) ? cnt_m : held_m;
        rd_m     = (min_m > MW'(MAX_READ_BURST)) ? MW'(MAX_READ_BURST) : min_m;
        rd_n     = RW'(rd_m);
        disc_n   = HW'(min_m);
        disc_sum = SW'(r_rp) + SW'(disc_n);
        disc_rp  = (disc_sum >= SW'(FIFO_FRAMES)) ? PW'(disc_sum - SW'(FIFO_FRAMES))
                                                  : PW'(disc_sum);
    end

    // FSM outputs
    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = !r_pend && out_free;
            end
            ST_READ: begin
                issue = (r_remain != '0) && (!r_pend || pend_move);
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign o_in_stall = !in_ready;

    // FSM next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (go_read) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (issue && r_remain == RW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // pointer and count updates
    always_comb begin
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_held   = r_held;
        n_drop   = r_drop;
        n_remain = r_remain;
        n_done   = r_done;
        ram_we   = 1'b0;
        imm_load = 1'b0;
        imm_done = '0;
        go_read  = 1'b0;
        if (in_acc) begin
            case (i_in_data.func)
                FUNC_PUSH: begin
                    ram_we   = 1'b1;
                    imm_load = 1'b1;
                    n_wp     = ring_next(r_wp);
                    if (r_held == HW'(FIFO_FRAMES)) begin
                        // drop the oldest frame to make room
                        n_rp   = ring_next(r_rp);
                        n_drop = r_drop + 1'b1;
                    end else begin
                        n_held = r_held + 1'b1;
                    end
                end
                FUNC_READ: begin
                    if (rd_n == '0) begin
                        imm_load = 1'b1;
                    end else begin
                        go_read  = 1'b1;
                        n_remain = rd_n;
                        n_done   = '0;
                    end
                end
                FUNC_DISCARD: begin
                    imm_load = 1'b1;
                    imm_done = CNT_W'(min_m);
                    n_rp     = disc_rp;
                    n_held   = r_held - disc_n;
                end
                FUNC_CLEAR: begin
                    imm_load = 1'b1;
                    n_rp     = '0;
                    n_wp     = '0;
                    n_held   = '0;
                end
                default: begin
                    imm_load = 1'b1;
                end
            endcase
        end
        if (issue) begin
            n_rp     = ring_next(r_rp);
            n_held   = r_held - 1'b1;
            n_remain = r_remain - 1'b1;
            n_done   = r_done + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_held   <= '0;
            r_drop   <= '0;
            r_remain <= '0;
            r_done   <= '0;
        end else begin
            r_state  <= n_state;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_held   <= n_held;
            r_drop   <= n_drop;
            r_remain <= n_remain;
            r_done   <= n_done;
        end
    end

    // frame in flight out of the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (issue) begin
            r_pend <= 1'b1;
        end else if (pend_move) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_last <= (r_remain == RW'(1));
            r_pend_done <= n_done;
            r_pend_occ  <= n_held;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (imm_load || pend_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_out.frame_valid   <= 1'b1;
            r_out.left_out      <= ram_rdata[SAMPLE_W-1:0];
            r_out.right_out     <= ram_rdata[FRAME_W-1:SAMPLE_W];
            r_out.last          <= r_pend_last;
            r_out.done_count    <= CNT_W'(r_pend_done);
            r_out.occupancy     <= CNT_W'(r_pend_occ);
            r_out.dropped_total <= r_drop;
        end else if (imm_load) begin
            r_out.frame_valid   <= 1'b0;
            r_out.left_out      <= '0;
            r_out.right_out     <= '0;
            r_out.last          <= 1'b1;
            r_out.done_count    <= imm_done;
            r_out.occupancy     <= CNT_W'(n_held);
            r_out.dropped_total <= n_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/sffdo_chk.sv =====
// ----------------------------------------------------------------------------
// sffdo_chk
// Port-level checks of the stereo frame FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module sffdo_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input sffdo_pkg::t_req i_in_data,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input sffdo_pkg::t_rsp o_out_data
);

    import sffdo_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_nonframe_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.frame_valid |-> o_out_data.last)
        else $error("result without a frame is not marked last");

    a_nonframe_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.frame_valid
            |-> o_out_data.left_out == '0 && o_out_data.right_out == '0)
        else $error("result without a frame carries samples");

    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_valid |-> o_out_data.done_count != '0)
        else $error("read frame reports no progress");

endmodule

bind stereo_frame_fifo_drop_oldest_unit sffdo_chk u_sffdo_chk (.*);
